### sv/mis_pkg.sv
// Shared types, constants and opcode masks for the minicomputer instruction step core.
`default_nettype none
package mis_pkg;

	localparam int unsigned MEM_BYTES = 65536;
	localparam int unsigned MEM_AW = $clog2(MEM_BYTES);

	localparam logic [15:0] RESET_PC = 16'o001000;
	localparam logic [15:0] CONSOLE_ADDR = 16'o177566;

	localparam logic [15:0] MASK_ADD = 16'o170000;
	localparam logic [15:0] CODE_ADD = 16'o060000;
	localparam logic [15:0] MASK_MOV = 16'o070000;
	localparam logic [15:0] CODE_MOV = 16'o010000;
	localparam logic [15:0] MASK_ONE = 16'o177700;
	localparam logic [15:0] CODE_INC = 16'o005200;
	localparam logic [15:0] CODE_CLR = 16'o005000;
	localparam logic [15:0] MASK_SOB = 16'o177000;
	localparam logic [15:0] CODE_SOB = 16'o077000;
	localparam logic [15:0] CODE_SCC = 16'o000277;
	localparam logic [15:0] CODE_CCC = 16'o000257;
	localparam logic [15:0] MASK_BR = 16'o177400;
	localparam logic [15:0] CODE_BR = 16'o000400;
	localparam logic [15:0] CODE_BEQ = 16'o001400;
	localparam logic [15:0] CODE_BPL = 16'o100000;
	localparam logic [15:0] MASK_TST = 16'o077700;
	localparam logic [15:0] CODE_TST = 16'o005700;

	localparam logic [2:0] ST_RUN = 3'd0;
	localparam logic [2:0] ST_HALT = 3'd1;
	localparam logic [2:0] ST_BAD_MODE = 3'd2;
	localparam logic [2:0] ST_ODD = 3'd3;
	localparam logic [2:0] ST_BAD_OP = 3'd4;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_EXEC = 2'd1,
		CMD_RDREG = 2'd2,
		CMD_RDMEM = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		CLS_HALT, CLS_ADD, CLS_MOV, CLS_INC, CLS_SOB, CLS_CLR,
		CLS_SCC, CLS_CCC, CLS_BR, CLS_TST, CLS_BAD
	} cls_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LATCH, OP_WR_LOAD, OP_RD_REG, OP_RD_CMD, OP_TAKE_RV,
		OP_START, OP_RD_LO, OP_RD_HI, OP_TAKE_LO, OP_TAKE_HI, OP_IR,
		OP_RESOLVE, OP_PTR, OP_FETCH_REG, OP_MAR_EA, OP_TAKE_VAL, OP_ALU,
		OP_ST_REG, OP_WR_LO, OP_WR_HI, OP_COMMIT, OP_HALT, OP_SOB1, OP_SOB2,
		OP_SCC, OP_CCC, OP_BRANCH, OP_FAULT, OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic opd;
		logic [2:0] fcode;
	} dp_cmd_t;

	typedef struct packed {
		cmd_t cmd;
		cls_t cls;
		logic [2:0] mode;
		logic in_reg;
		logic mar_odd;
		logic ea_odd;
		logic byte_op;
		logic running;
	} dp_stat_t;

endpackage
`default_nettype wire

### sv/mis_datapath.sv
// Datapath: register file, byte memory, operand registers, ALU and result register.
`default_nettype none
module mis_datapath import mis_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire dp_cmd_t cmd,
	output dp_stat_t stat,
	input wire logic start_address_we,
	input wire logic [15:0] start_address,
	input wire logic [1:0] command,
	input wire logic [15:0] mem_address,
	input wire logic [7:0] load_byte,
	input wire logic [2:0] reg_index,
	output logic [2:0] status,
	output logic [15:0] program_counter,
	output logic [3:0] flags,
	output logic console_valid,
	output logic [7:0] console_char,
	output logic [15:0] read_value
);

	logic [7:0] mem [MEM_BYTES];
	logic [7:0] rdata_q;

	logic [15:0] regs_q [8];
	logic [15:0] snap_q [8];
	logic [15:0] ir_q, mar_q, ea_q, mdr_q, s_q, d_q, res_q, addr_q, rv_q;
	logic [7:0] byte_q, con_char_q;
	logic [2:0] ridx_q, stat_q;
	logic [3:0] cc_q, nf_q;
	cmd_t cmd_q;
	logic in_reg_q, con_q;

	logic [5:0] spec;
	logic [2:0] mode, rsel, rn;
	logic [15:0] rval, step, fetch_val, wfull;
	logic bop, take, mem_we, mem_re;
	logic [MEM_AW-1:0] mem_a;
	logic [7:0] mem_wd;
	logic [16:0] sum;
	logic [15:0] alu_res;
	logic [3:0] alu_nf;
	cls_t cls;

	assign spec = cmd.opd ? ir_q[5:0] : ir_q[11:6];
	assign mode = spec[5:3];
	assign rn = spec[2:0];
	assign bop = ir_q[15];
	assign step = (bop && (rn < 3'd6)) ? 16'd1 : 16'd2;

	always_comb begin
		unique case (cmd.op)
			OP_RD_REG: rsel = ridx_q;
			OP_FETCH_REG: rsel = ea_q[2:0];
			OP_SOB1, OP_SOB2: rsel = ir_q[8:6];
			default: rsel = rn;
		endcase
	end
	assign rval = regs_q[rsel];
	assign fetch_val = bop ? {8'd0, rval[7:0]} : rval;

	always_comb begin
		priority if (ir_q == 16'd0) cls = CLS_HALT;
		else if ((ir_q & MASK_ADD) == CODE_ADD) cls = CLS_ADD;
		else if ((ir_q & MASK_MOV) == CODE_MOV) cls = CLS_MOV;
		else if ((ir_q & MASK_ONE) == CODE_INC) cls = CLS_INC;
		else if ((ir_q & MASK_SOB) == CODE_SOB) cls = CLS_SOB;
		else if ((ir_q & MASK_ONE) == CODE_CLR) cls = CLS_CLR;
		else if (ir_q == CODE_SCC) cls = CLS_SCC;
		else if (ir_q == CODE_CCC) cls = CLS_CCC;
		else if ((ir_q & MASK_BR) == CODE_BR || (ir_q & MASK_BR) == CODE_BEQ
			|| (ir_q & MASK_BR) == CODE_BPL) cls = CLS_BR;
		else if ((ir_q & MASK_TST) == CODE_TST) cls = CLS_TST;
		else cls = CLS_BAD;
	end

	always_comb begin
		priority if ((ir_q & MASK_BR) == CODE_BEQ) take = cc_q[2];
		else if ((ir_q & MASK_BR) == CODE_BPL) take = !cc_q[3];
		else take = 1'b1;
	end

	assign sum = {1'b0, s_q} + {1'b0, d_q};
	always_comb begin
		alu_res = 16'd0;
		alu_nf = cc_q;
		unique case (cls)
			CLS_ADD: begin
				alu_res = sum[15:0];
				alu_nf = {sum[15], sum[15:0] == 16'd0,
					(~(s_q[15] ^ d_q[15])) & (s_q[15] ^ sum[15]), sum[16]};
			end
			CLS_MOV: begin
				alu_res = s_q;
				alu_nf = bop ? {s_q[7], s_q[7:0] == 8'd0, 1'b0, cc_q[0]}
					: {s_q[15], s_q == 16'd0, 1'b0, cc_q[0]};
			end
			CLS_INC: begin
				alu_res = d_q + 16'd1;
				alu_nf = {alu_res[15], alu_res == 16'd0, d_q == 16'h7fff, cc_q[0]};
			end
			CLS_CLR: begin
				alu_res = 16'd0;
				alu_nf = 4'b0100;
			end
			CLS_TST: begin
				alu_nf = bop ? {d_q[7], d_q[7:0] == 8'd0, 2'b00}
					: {d_q[15], d_q == 16'd0, 2'b00};
			end
			default: begin
				alu_res = 16'd0;
			end
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		mem_re = 1'b0;
		wfull = mar_q;
		mem_wd = res_q[7:0];
		unique case (cmd.op)
			OP_WR_LOAD: begin
				mem_we = 1'b1;
				wfull = addr_q;
				mem_wd = byte_q;
			end
			OP_RD_CMD: begin
				mem_re = 1'b1;
				wfull = addr_q;
			end
			OP_RD_LO: mem_re = 1'b1;
			OP_RD_HI: begin
				mem_re = 1'b1;
				wfull = mar_q + 16'd1;
			end
			OP_WR_LO: begin
				mem_we = 1'b1;
				wfull = ea_q;
			end
			OP_WR_HI: begin
				mem_we = 1'b1;
				wfull = ea_q + 16'd1;
				mem_wd = res_q[15:8];
			end
			default: wfull = mar_q;
		endcase
	end
	assign mem_a = wfull[MEM_AW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_a] <= mem_wd;
		if (mem_re) rdata_q <= mem[mem_a];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) regs_q[i] <= 16'd0;
			regs_q[7] <= RESET_PC;
			cc_q <= 4'd0;
			stat_q <= ST_RUN;
		end else if (start_address_we) begin
			regs_q[7] <= start_address;
		end else begin
			unique case (cmd.op)
				OP_IR: regs_q[7] <= regs_q[7] + 16'd2;
				OP_RESOLVE: begin
					unique case (mode)
						3'd2: regs_q[rn] <= rval + step;
						3'd3: regs_q[rn] <= rval + 16'd2;
						3'd4: regs_q[rn] <= rval - step;
						3'd5: regs_q[rn] <= rval - 16'd2;
						default: ;
					endcase
				end
				OP_ST_REG: begin
					regs_q[ea_q[2:0]] <= bop ? {{8{res_q[7]}}, res_q[7:0]} : res_q;
					cc_q <= nf_q;
				end
				OP_COMMIT: cc_q <= nf_q;
				OP_HALT: stat_q <= ST_HALT;
				OP_SOB1: regs_q[rsel] <= rval - 16'd1;
				OP_SOB2: if (rval != 16'd0)
					regs_q[7] <= regs_q[7] - {9'd0, ir_q[5:0], 1'b0};
				OP_SCC: cc_q <= 4'hf;
				OP_CCC: cc_q <= 4'h0;
				OP_BRANCH: if (take)
					regs_q[7] <= regs_q[7] + {{7{ir_q[7]}}, ir_q[7:0], 1'b0};
				OP_FAULT: begin
					for (int i = 0; i < 8; i++) regs_q[i] <= snap_q[i];
					stat_q <= cmd.fcode;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			con_q <= 1'b0;
			cmd_q <= CMD_LOAD;
		end else begin
			unique case (cmd.op)
				OP_LATCH: begin
					cmd_q <= cmd_t'(command);
					con_q <= 1'b0;
				end
				OP_WR_LO, OP_WR_HI: if (wfull == CONSOLE_ADDR) con_q <= 1'b1;
				OP_FAULT: con_q <= 1'b0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LATCH: begin
				addr_q <= mem_address;
				byte_q <= load_byte;
				ridx_q <= reg_index;
				rv_q <= 16'd0;
				con_char_q <= 8'd0;
			end
			OP_RD_REG: rv_q <= rval;
			OP_TAKE_RV: rv_q <= {8'd0, rdata_q};
			OP_START: begin
				for (int i = 0; i < 8; i++) snap_q[i] <= regs_q[i];
				mar_q <= regs_q[7];
			end
			OP_RD_HI: mdr_q[7:0] <= rdata_q;
			OP_TAKE_LO: mdr_q <= {8'd0, rdata_q};
			OP_TAKE_HI: mdr_q[15:8] <= rdata_q;
			OP_IR: ir_q <= mdr_q;
			OP_RESOLVE: begin
				in_reg_q <= (mode == 3'd0);
				unique case (mode)
					3'd0: ea_q <= {13'd0, rn};
					3'd3: mar_q <= rval;
					3'd4: ea_q <= rval - step;
					3'd5: mar_q <= rval - 16'd2;
					default: ea_q <= rval;
				endcase
			end
			OP_PTR: ea_q <= mdr_q;
			OP_FETCH_REG: if (cmd.opd) d_q <= fetch_val; else s_q <= fetch_val;
			OP_MAR_EA: mar_q <= ea_q;
			OP_TAKE_VAL: if (cmd.opd) d_q <= mdr_q; else s_q <= mdr_q;
			OP_ALU: begin
				res_q <= alu_res;
				nf_q <= alu_nf;
			end
			OP_WR_LO: if (wfull == CONSOLE_ADDR) con_char_q <= mem_wd;
			OP_WR_HI: if (wfull == CONSOLE_ADDR) con_char_q <= mem_wd;
			OP_FAULT: con_char_q <= 8'd0;
			OP_EMIT: begin
				status <= stat_q;
				program_counter <= regs_q[7];
				flags <= cc_q;
				console_valid <= con_q;
				console_char <= con_char_q;
				read_value <= rv_q;
			end
			default: ;
		endcase
	end

	assign stat = '{cmd: cmd_q, cls: cls, mode: mode, in_reg: in_reg_q, mar_odd: mar_q[0],
		ea_odd: ea_q[0], byte_op: bop, running: stat_q == ST_RUN};

endmodule
`default_nettype wire

### sv/mis_ctrl.sv
// Controller: sequences commands, instruction fetch, operand access and write-back.
`default_nettype none
module mis_ctrl import mis_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input wire logic out_stall,
	input wire dp_stat_t stat,
	output dp_cmd_t cmd
);

	typedef enum logic [16:0] {
		S_IDLE = 17'h00001, S_CMD = 17'h00002, S_RDM = 17'h00004, S_RD0 = 17'h00008,
		S_RD1 = 17'h00010, S_RD2 = 17'h00020, S_RET = 17'h00040, S_DECODE = 17'h00080,
		S_SOB2 = 17'h00100, S_RES = 17'h00200, S_OPND = 17'h00400, S_NEXT = 17'h00800,
		S_ALU = 17'h01000, S_STORE = 17'h02000, S_WRHI = 17'h04000,
		S_COMMIT = 17'h08000, S_DONE = 17'h10000
	} state_t;

	typedef enum logic [1:0] {PH_FETCH, PH_PTR, PH_VAL} phase_t;

	state_t state_q, state_d;
	phase_t phase_q, phase_d;
	logic opd_q, opd_d, wd_q, wd_d, out_valid_q, emit;
	logic need_val;

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign need_val = !opd_q || stat.cls == CLS_ADD || stat.cls == CLS_INC
		|| stat.cls == CLS_TST;

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		opd_d = opd_q;
		wd_d = wd_q;
		emit = 1'b0;
		cmd = '{op: OP_NONE, opd: opd_q, fcode: ST_RUN};
		unique case (state_q)
			S_IDLE: if (in_valid) begin
				cmd.op = OP_LATCH;
				state_d = S_CMD;
			end
			S_CMD: begin
				unique case (stat.cmd)
					CMD_LOAD: begin
						cmd.op = OP_WR_LOAD;
						state_d = S_DONE;
					end
					CMD_RDREG: begin
						cmd.op = OP_RD_REG;
						state_d = S_DONE;
					end
					CMD_RDMEM: begin
						cmd.op = OP_RD_CMD;
						state_d = S_RDM;
					end
					CMD_EXEC: if (stat.running) begin
						cmd.op = OP_START;
						phase_d = PH_FETCH;
						wd_d = 1'b1;
						state_d = S_RD0;
					end else begin
						state_d = S_DONE;
					end
				endcase
			end
			S_RDM: begin
				cmd.op = OP_TAKE_RV;
				state_d = S_DONE;
			end
			S_RD0: if (wd_q && stat.mar_odd) begin
				cmd.op = OP_FAULT;
				cmd.fcode = ST_ODD;
				state_d = S_DONE;
			end else begin
				cmd.op = OP_RD_LO;
				state_d = S_RD1;
			end
			S_RD1: if (wd_q) begin
				cmd.op = OP_RD_HI;
				state_d = S_RD2;
			end else begin
				cmd.op = OP_TAKE_LO;
				state_d = S_RET;
			end
			S_RD2: begin
				cmd.op = OP_TAKE_HI;
				state_d = S_RET;
			end
			S_RET: begin
				unique case (phase_q)
					PH_FETCH: begin
						cmd.op = OP_IR;
						state_d = S_DECODE;
					end
					PH_PTR: begin
						cmd.op = OP_PTR;
						state_d = S_OPND;
					end
					default: begin
						cmd.op = OP_TAKE_VAL;
						state_d = S_NEXT;
					end
				endcase
			end
			S_DECODE: begin
				state_d = S_DONE;
				unique case (stat.cls)
					CLS_HALT: cmd.op = OP_HALT;
					CLS_SCC: cmd.op = OP_SCC;
					CLS_CCC: cmd.op = OP_CCC;
					CLS_BR: cmd.op = OP_BRANCH;
					CLS_SOB: begin
						cmd.op = OP_SOB1;
						state_d = S_SOB2;
					end
					CLS_ADD, CLS_MOV: begin
						opd_d = 1'b0;
						state_d = S_RES;
					end
					CLS_INC, CLS_CLR, CLS_TST: begin
						opd_d = 1'b1;
						state_d = S_RES;
					end
					default: begin
						cmd.op = OP_FAULT;
						cmd.fcode = ST_BAD_OP;
					end
				endcase
			end
			S_SOB2: begin
				cmd.op = OP_SOB2;
				state_d = S_DONE;
			end
			S_RES: if (stat.mode == 3'd6 || stat.mode == 3'd7) begin
				cmd.op = OP_FAULT;
				cmd.fcode = ST_BAD_MODE;
				state_d = S_DONE;
			end else begin
				cmd.op = OP_RESOLVE;
				if (stat.mode == 3'd3 || stat.mode == 3'd5) begin
					phase_d = PH_PTR;
					wd_d = 1'b1;
					state_d = S_RD0;
				end else begin
					state_d = S_OPND;
				end
			end
			S_OPND: if (!need_val) begin
				state_d = S_NEXT;
			end else if (stat.in_reg) begin
				cmd.op = OP_FETCH_REG;
				state_d = S_NEXT;
			end else begin
				cmd.op = OP_MAR_EA;
				phase_d = PH_VAL;
				wd_d = !stat.byte_op;
				state_d = S_RD0;
			end
			S_NEXT: if (!opd_q) begin
				opd_d = 1'b1;
				state_d = S_RES;
			end else begin
				state_d = S_ALU;
			end
			S_ALU: begin
				cmd.op = OP_ALU;
				state_d = S_STORE;
			end
			S_STORE: if (stat.cls == CLS_TST) begin
				cmd.op = OP_COMMIT;
				state_d = S_DONE;
			end else if (stat.in_reg) begin
				cmd.op = OP_ST_REG;
				state_d = S_DONE;
			end else if (!stat.byte_op && stat.ea_odd) begin
				cmd.op = OP_FAULT;
				cmd.fcode = ST_ODD;
				state_d = S_DONE;
			end else begin
				cmd.op = OP_WR_LO;
				state_d = stat.byte_op ? S_COMMIT : S_WRHI;
			end
			S_WRHI: begin
				cmd.op = OP_WR_HI;
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.op = OP_COMMIT;
				state_d = S_DONE;
			end
			S_DONE: if (!out_valid_q || !out_stall) begin
				cmd.op = OP_EMIT;
				emit = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_FETCH;
			opd_q <= 1'b0;
			wd_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			opd_q <= opd_d;
			wd_q <= wd_d;
			if (emit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

### sv/minicomputer_instruction_step_top.sv
// Top level of the minicomputer instruction step core.
// One word in gives one word out. A load or register read passes through the command and
// done states; a byte read also passes the state that takes the memory byte. Branch, SCC,
// CCC and HALT are the shortest instructions, SOB needs a second step, and ADD with
// deferred operands on both sides is the longest. Every instruction word and pointer, and
// every operand in memory, moves one byte per cycle through the single port of the 64 KiB
// byte memory, which is the limit. An execute on a stopped core skips to the done state,
// where output stalls hold the core. Memory is not cleared at reset. A new word is taken
// once the previous result sits in the output register; start_address writes load the PC.
`default_nettype none
module minicomputer_instruction_step_top import mis_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start_address_we,
	input wire logic [15:0] start_address,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [1:0] command,
	input wire logic [15:0] mem_address,
	input wire logic [7:0] load_byte,
	input wire logic [2:0] reg_index,
	output logic out_valid,
	input wire logic out_stall,
	output logic [2:0] status,
	output logic [15:0] program_counter,
	output logic [3:0] flags,
	output logic console_valid,
	output logic [7:0] console_char,
	output logic [15:0] read_value
);

	dp_cmd_t cmd;
	dp_stat_t stat;

	mis_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd)
	);

	mis_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.start_address_we(start_address_we), .start_address(start_address),
		.command(command), .mem_address(mem_address), .load_byte(load_byte),
		.reg_index(reg_index), .status(status), .program_counter(program_counter),
		.flags(flags), .console_valid(console_valid), .console_char(console_char),
		.read_value(read_value)
	);

endmodule
`default_nettype wire
